### sv/ubrg_pkg.sv
// Package with the types, constants and budget check shared by the usage budget and resource gate.
package ubrg_pkg;

    localparam int unsigned BudgetWidth = 40;
    localparam int unsigned TimeWidth   = 16;
    localparam int unsigned PctWidth    = 7;
    localparam int unsigned CpuWidth    = 10;
    localparam int unsigned RunWidth    = 8;
    localparam int unsigned RssWidth    = 48;
    localparam int unsigned ProdWidth   = BudgetWidth + PctWidth;
    localparam int unsigned CfgIdxWidth = 3;
    localparam int unsigned CfgDataWidth = 48;

    localparam logic [ProdWidth-1:0] WarnScale = ProdWidth'(100);
    localparam logic [RunWidth-1:0]  RunMax    = '1;

    typedef enum logic [1:0] {
        MODE_USAGE    = 2'd0,
        MODE_RESOURCE = 2'd1,
        MODE_TIME     = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_COST_CEILING   = 3'd0,
        CFG_TOKEN_CEILING  = 3'd1,
        CFG_TIME_LIMIT     = 3'd2,
        CFG_WARN_PERCENT   = 3'd3,
        CFG_CPU_LIMIT      = 3'd4,
        CFG_DEBOUNCE_COUNT = 3'd5,
        CFG_RSS_LIMIT      = 3'd6,
        CFG_NONE           = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic over;
        logic warned;
        logic over_ev;
        logic warn_ev;
    } t_budget;

    // One budget check: the over flag latches once at the ceiling, and below it a
    // single warning is given when value*100 reaches warn_percent*ceiling.
    function automatic t_budget check_budget(
        input logic [BudgetWidth-1:0] value,
        input logic [BudgetWidth-1:0] ceiling,
        input logic [PctWidth-1:0]    warn_pct,
        input logic                   over,
        input logic                   warned
    );
        t_budget                res;
        logic [ProdWidth-1:0]   scaled_value;
        logic [ProdWidth-1:0]   warn_level;
        scaled_value = ProdWidth'(value) * WarnScale;
        warn_level   = ProdWidth'(warn_pct) * ProdWidth'(ceiling);
        res.over    = over;
        res.warned  = warned;
        res.over_ev = 1'b0;
        res.warn_ev = 1'b0;
        if (ceiling != '0) begin
            if (value >= ceiling) begin
                if (!over) begin
                    res.over    = 1'b1;
                    res.over_ev = 1'b1;
                end
            end else if (scaled_value >= warn_level && !warned) begin
                res.warned  = 1'b1;
                res.warn_ev = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

### sv/usage_budget_and_resource_gate_top.sv
// Top level of the usage budget monitor and debounced resource gate.
// An accepted input transaction passes the input register and then the result register.
// Throughput: one transaction per cycle while i_out_ready does not stall the result register;
// one pass of compares and six 40x7 multiplies between the two registers sets the cycle.
// Reset is synchronous and active low: it clears the over and warned flags, the CPU run count
// and the gate, and loads the configuration registers with their default values.
module usage_budget_and_resource_gate_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ubrg_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [ubrg_pkg::CfgDataWidth-1:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [39:0] i_tokens,
    input  logic [39:0] i_cost,
    input  logic [9:0]  i_cpu_load,
    input  logic [47:0] i_rss_bytes,
    input  logic [15:0] i_elapsed_minutes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_cost_over_event,
    output logic        o_cost_warn_event,
    output logic        o_token_over_event,
    output logic        o_token_warn_event,
    output logic        o_time_over_event,
    output logic        o_time_warn_event,
    output logic        o_gate_set_event,
    output logic        o_gate_cause,
    output logic        o_gate_clear_event,
    output logic        o_gate_active,
    output logic        o_block_autonomy
);

    // Configuration registers
    logic [ubrg_pkg::BudgetWidth-1:0] r_cost_ceiling;
    logic [ubrg_pkg::BudgetWidth-1:0] r_token_ceiling;
    logic [ubrg_pkg::TimeWidth-1:0]   r_time_limit;
    logic [ubrg_pkg::PctWidth-1:0]    r_warn_percent;
    logic [ubrg_pkg::CpuWidth-1:0]    r_cpu_limit;
    logic [ubrg_pkg::RunWidth-1:0]    r_debounce_count;
    logic [ubrg_pkg::RssWidth-1:0]    r_rss_limit;

    // Input register
    logic                             r_in_valid;
    ubrg_pkg::t_mode                  r_mode;
    logic [39:0]                      r_tokens;
    logic [39:0]                      r_cost;
    logic [9:0]                       r_cpu_load;
    logic [47:0]                      r_rss_bytes;
    logic [15:0]                      r_elapsed_minutes;

    // Block state
    logic r_cost_over, r_token_over, r_time_over;
    logic r_cost_warned, r_token_warned, r_time_warned;
    logic [ubrg_pkg::RunWidth-1:0] r_cpu_over_run;
    logic r_gate_on;

    // Result register
    logic r_out_valid;
    logic r_cost_over_ev, r_cost_warn_ev, r_token_over_ev, r_token_warn_ev;
    logic r_time_over_ev, r_time_warn_ev;
    logic r_gate_set_ev, r_gate_cause, r_gate_clear_ev, r_gate_active, r_block_autonomy;

    logic advance;

    ubrg_pkg::t_budget cost_chk, token_chk, time_chk;

    logic n_cost_over, n_token_over, n_time_over;
    logic n_cost_warned, n_token_warned, n_time_warned;
    logic [ubrg_pkg::RunWidth-1:0] n_cpu_over_run;
    logic n_gate_on;
    logic n_cost_over_ev, n_cost_warn_ev, n_token_over_ev, n_token_warn_ev;
    logic n_time_over_ev, n_time_warn_ev;
    logic n_gate_set_ev, n_gate_cause, n_gate_clear_ev;
    logic gate_mid;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    assign cost_chk  = ubrg_pkg::check_budget(r_cost, r_cost_ceiling, r_warn_percent,
                                              r_cost_over, r_cost_warned);
    assign token_chk = ubrg_pkg::check_budget(r_tokens, r_token_ceiling, r_warn_percent,
                                              r_token_over, r_token_warned);
    assign time_chk  = ubrg_pkg::check_budget(ubrg_pkg::BudgetWidth'(r_elapsed_minutes),
                                              ubrg_pkg::BudgetWidth'(r_time_limit),
                                              r_warn_percent, r_time_over, r_time_warned);

    always_comb begin
        n_cost_over     = r_cost_over;
        n_token_over    = r_token_over;
        n_time_over     = r_time_over;
        n_cost_warned   = r_cost_warned;
        n_token_warned  = r_token_warned;
        n_time_warned   = r_time_warned;
        n_cpu_over_run  = r_cpu_over_run;
        n_gate_on       = r_gate_on;
        n_cost_over_ev  = 1'b0;
        n_cost_warn_ev  = 1'b0;
        n_token_over_ev = 1'b0;
        n_token_warn_ev = 1'b0;
        n_time_over_ev  = 1'b0;
        n_time_warn_ev  = 1'b0;
        n_gate_set_ev   = 1'b0;
        n_gate_cause    = 1'b0;
        n_gate_clear_ev = 1'b0;
        gate_mid        = r_gate_on;
        unique case (r_mode)
            ubrg_pkg::MODE_USAGE: begin
                n_cost_over     = cost_chk.over;
                n_cost_warned   = cost_chk.warned;
                n_cost_over_ev  = cost_chk.over_ev;
                n_cost_warn_ev  = cost_chk.warn_ev;
                n_token_over    = token_chk.over;
                n_token_warned  = token_chk.warned;
                n_token_over_ev = token_chk.over_ev;
                n_token_warn_ev = token_chk.warn_ev;
            end
            ubrg_pkg::MODE_TIME: begin
                n_time_over    = time_chk.over;
                n_time_warned  = time_chk.warned;
                n_time_over_ev = time_chk.over_ev;
                n_time_warn_ev = time_chk.warn_ev;
            end
            ubrg_pkg::MODE_RESOURCE: begin
                if (r_cpu_load >= r_cpu_limit) begin
                    if (r_cpu_over_run != ubrg_pkg::RunMax) begin
                        n_cpu_over_run = r_cpu_over_run + 1'b1;
                    end
                    if (!r_gate_on && n_cpu_over_run >= r_debounce_count) begin
                        gate_mid      = 1'b1;
                        n_gate_set_ev = 1'b1;
                    end
                end else begin
                    n_cpu_over_run = '0;
                    if (r_gate_on && r_rss_bytes < r_rss_limit) begin
                        gate_mid        = 1'b0;
                        n_gate_clear_ev = 1'b1;
                    end
                end
                n_gate_on = gate_mid;
                if (r_rss_bytes >= r_rss_limit && !gate_mid) begin
                    n_gate_on     = 1'b1;
                    n_gate_set_ev = 1'b1;
                    n_gate_cause  = 1'b1;
                end
            end
            ubrg_pkg::MODE_UNUSED: begin
                n_gate_on = r_gate_on;
            end
            default: begin
                n_gate_on = r_gate_on;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_ceiling   <= '0;
            r_token_ceiling  <= '0;
            r_time_limit     <= '0;
            r_warn_percent   <= ubrg_pkg::PctWidth'(80);
            r_cpu_limit      <= ubrg_pkg::CpuWidth'(90);
            r_debounce_count <= ubrg_pkg::RunWidth'(3);
            r_rss_limit      <= '1;
        end else if (i_cfg_valid) begin
            unique case (ubrg_pkg::t_cfg_idx'(i_cfg_index))
                ubrg_pkg::CFG_COST_CEILING:
                    r_cost_ceiling <= i_cfg_data[ubrg_pkg::BudgetWidth-1:0];
                ubrg_pkg::CFG_TOKEN_CEILING:
                    r_token_ceiling <= i_cfg_data[ubrg_pkg::BudgetWidth-1:0];
                ubrg_pkg::CFG_TIME_LIMIT:
                    r_time_limit <= i_cfg_data[ubrg_pkg::TimeWidth-1:0];
                ubrg_pkg::CFG_WARN_PERCENT:
                    r_warn_percent <= i_cfg_data[ubrg_pkg::PctWidth-1:0];
                ubrg_pkg::CFG_CPU_LIMIT:
                    r_cpu_limit <= i_cfg_data[ubrg_pkg::CpuWidth-1:0];
                ubrg_pkg::CFG_DEBOUNCE_COUNT:
                    r_debounce_count <= i_cfg_data[ubrg_pkg::RunWidth-1:0];
                ubrg_pkg::CFG_RSS_LIMIT:
                    r_rss_limit <= i_cfg_data[ubrg_pkg::RssWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_mode            <= ubrg_pkg::t_mode'(i_mode);
            r_tokens          <= i_tokens;
            r_cost            <= i_cost;
            r_cpu_load        <= i_cpu_load;
            r_rss_bytes       <= i_rss_bytes;
            r_elapsed_minutes <= i_elapsed_minutes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost_over    <= 1'b0;
            r_token_over   <= 1'b0;
            r_time_over    <= 1'b0;
            r_cost_warned  <= 1'b0;
            r_token_warned <= 1'b0;
            r_time_warned  <= 1'b0;
            r_cpu_over_run <= '0;
            r_gate_on      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_cost_over    <= n_cost_over;
                r_token_over   <= n_token_over;
                r_time_over    <= n_time_over;
                r_cost_warned  <= n_cost_warned;
                r_token_warned <= n_token_warned;
                r_time_warned  <= n_time_warned;
                r_cpu_over_run <= n_cpu_over_run;
                r_gate_on      <= n_gate_on;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (advance) begin
            r_cost_over_ev   <= n_cost_over_ev;
            r_cost_warn_ev   <= n_cost_warn_ev;
            r_token_over_ev  <= n_token_over_ev;
            r_token_warn_ev  <= n_token_warn_ev;
            r_time_over_ev   <= n_time_over_ev;
            r_time_warn_ev   <= n_time_warn_ev;
            r_gate_set_ev    <= n_gate_set_ev;
            r_gate_cause     <= n_gate_cause;
            r_gate_clear_ev  <= n_gate_clear_ev;
            r_gate_active    <= n_gate_on;
            r_block_autonomy <= n_cost_over || n_token_over || n_time_over || n_gate_on;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_cost_over_event  = r_cost_over_ev;
    assign o_cost_warn_event  = r_cost_warn_ev;
    assign o_token_over_event = r_token_over_ev;
    assign o_token_warn_event = r_token_warn_ev;
    assign o_time_over_event  = r_time_over_ev;
    assign o_time_warn_event  = r_time_warn_ev;
    assign o_gate_set_event   = r_gate_set_ev;
    assign o_gate_cause       = r_gate_cause;
    assign o_gate_clear_event = r_gate_clear_ev;
    assign o_gate_active      = r_gate_active;
    assign o_block_autonomy   = r_block_autonomy;

endmodule
